// ===== rtl/core/fttl_pkg.sv =====
`timescale 1ns / 1ps

package fttl_pkg;

    localparam int PointW  = 18;
    localparam int WorldW  = 20;
    localparam int RotW    = 13;
    localparam int ShW     = 13;
    localparam int ElW     = 11;
    localparam int CfgW    = 18;

    // CORDIC datapath: x/y wide enough for 2^31 * gain, z in Q16 degrees
    localparam int CxW     = 35;
    localparam int CzW     = 28;
    localparam int TableLen = 24;
    localparam int StepW   = 5;

    localparam int ProdW   = 55;
    localparam int SumW    = 41;
    localparam int SqW     = 46;
    localparam int RootW   = 23;
    localparam logic [StepW-1:0] SqTopK = 5'd22;

    localparam logic signed [CxW-1:0] GainQ30   = 35'sd652032874;
    localparam logic signed [CzW-1:0] Deg90Q16  = 28'sd5898240;
    localparam logic signed [CzW-1:0] Deg180Q16 = 28'sd11796480;
    localparam logic [SumW-1:0]       ReachQ16  = 41'd26214400;

    localparam logic [1:0] RegOffX = 2'd0;
    localparam logic [1:0] RegOffY = 2'd1;
    localparam logic [1:0] RegRot  = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ROT,
        S_ROT_WAIT,
        S_MUL,
        S_ACC,
        S_WORLD,
        S_REACH,
        S_SQRT_A,
        S_SQRT_A_WAIT,
        S_SQRT_B,
        S_SQRT_B_WAIT,
        S_ACOS,
        S_ACOS_WAIT,
        S_ATAN,
        S_ATAN_WAIT,
        S_FINAL
    } fttl_state_t;

    // round(atan(2^-i) degrees * 65536)
    function automatic logic [22:0] atan_lut(input logic [StepW-1:0] idx);
        logic [22:0] v;
        case (idx)
            5'd0:  v = 23'd2949120;
            5'd1:  v = 23'd1740967;
            5'd2:  v = 23'd919879;
            5'd3:  v = 23'd466945;
            5'd4:  v = 23'd234379;
            5'd5:  v = 23'd117304;
            5'd6:  v = 23'd58666;
            5'd7:  v = 23'd29335;
            5'd8:  v = 23'd14668;
            5'd9:  v = 23'd7334;
            5'd10: v = 23'd3667;
            5'd11: v = 23'd1833;
            5'd12: v = 23'd917;
            5'd13: v = 23'd458;
            5'd14: v = 23'd229;
            5'd15: v = 23'd115;
            5'd16: v = 23'd57;
            5'd17: v = 23'd29;
            5'd18: v = 23'd14;
            5'd19: v = 23'd7;
            5'd20: v = 23'd4;
            5'd21: v = 23'd2;
            5'd22: v = 23'd1;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/fttl_cordic.sv =====
`timescale 1ns / 1ps

module fttl_cordic import fttl_pkg::*; #(
    parameter int STEPS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic                  vec_mode,
    input  logic signed [CxW-1:0] x_in,
    input  logic signed [CxW-1:0] y_in,
    input  logic signed [CzW-1:0] z_in,
    output logic                  done,
    output logic signed [CxW-1:0] x_out,
    output logic signed [CxW-1:0] y_out,
    output logic signed [CzW-1:0] z_out
);

    localparam int NSTEPS = (STEPS > TableLen) ? TableLen : STEPS;
    localparam logic [StepW-1:0] LastIdx = StepW'(NSTEPS - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [StepW-1:0]      idx_reg, idx_next;
    logic                  mode_reg, mode_next;
    logic signed [CxW-1:0] x_reg, x_next;
    logic signed [CxW-1:0] y_reg, y_next;
    logic signed [CzW-1:0] z_reg, z_next;
    logic signed [CxW-1:0] dx, dy;
    logic signed [CzW-1:0] da;
    logic                  dir;

    always_comb begin
        dx = y_reg >>> idx_reg;
        dy = x_reg >>> idx_reg;
        da = CzW'(signed'({1'b0, atan_lut(idx_reg)}));
        // vectoring drives y to zero, rotation drives z to zero
        dir = mode_reg ? y_reg[CxW-1] : ~z_reg[CzW-1];
        busy_next = busy_reg;
        done_next = 1'b0;
        idx_next  = idx_reg;
        mode_next = mode_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (start) begin
            busy_next = 1'b1;
            idx_next  = '0;
            mode_next = vec_mode;
            x_next = x_in;
            y_next = y_in;
            z_next = z_in;
        end else if (busy_reg) begin
            if (dir) begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - da;
            end else begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + da;
            end
            idx_next = idx_reg + 1'b1;
            if (idx_reg == LastIdx) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        idx_reg  <= idx_next;
        mode_reg <= mode_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

// ===== rtl/core/fttl_isqrt.sv =====
`timescale 1ns / 1ps

module fttl_isqrt import fttl_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [SqW-1:0]   value,
    output logic             done,
    output logic [RootW-1:0] root
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [StepW-1:0] k_reg, k_next;
    logic [SqW-1:0]   v_reg, v_next;
    logic [SqW-1:0]   r_reg, r_next;
    logic [SqW-1:0]   bitv;
    logic [SqW-1:0]   trial;

    always_comb begin
        bitv  = SqW'(1) << {k_reg, 1'b0};
        trial = r_reg + bitv;
        busy_next = busy_reg;
        done_next = 1'b0;
        k_next = k_reg;
        v_next = v_reg;
        r_next = r_reg;
        if (start) begin
            busy_next = 1'b1;
            k_next = SqTopK;
            v_next = value;
            r_next = '0;
        end else if (busy_reg) begin
            // one result bit per cycle
            if (v_reg >= trial) begin
                v_next = v_reg - trial;
                r_next = (r_reg >> 1) + bitv;
            end else begin
                r_next = r_reg >> 1;
            end
            k_next = k_reg - 1'b1;
            if (k_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        k_reg <= k_next;
        v_reg <= v_next;
        r_reg <= r_next;
    end

    assign done = done_reg;
    assign root = r_reg[RootW-1:0];

endmodule

// ===== rtl/core/frame_transform_two_link_ik.sv =====
`timescale 1ns / 1ps

// channel   | dir | tdata (lsb first)                              | tuser
// s_        | in  | point_x[17:0] point_y[35:18] pad[39:36]        | -
// m_        | out | world_x[19:0] world_y[39:20] shoulder_out[52:40]
//           |     | elbow_out[63:53]                               | reachable
// cfg_      | in  | write only, cfg_addr selects offset_x/offset_y/rotation
//
// Each word runs, with N = min(CORDIC_STEPS, 24) steps per CORDIC pass: the
// rotation CORDIC, 4 products plus 2 squares on one multiplier, two
// square roots, acos and atan2 CORDIC passes. An unreachable point skips the
// last four. The core processes one word at a time.
// Reset (synchronous, aresetn low) clears state, offsets, rotation and output
// valid, sets shoulder 720, elbow 1440. A result held by m_tready low blocks the next result, not the next input.
module frame_transform_two_link_ik import fttl_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [39:0]     s_tdata,   // point_x, point_y
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [63:0]     m_tdata,   // world_x, world_y, shoulder_out, elbow_out
    output logic            m_tuser,   // reachable
    input  logic            cfg_wr_en,
    input  logic [1:0]      cfg_addr,
    input  logic [CfgW-1:0] cfg_wr_data
);

    fttl_state_t state_reg, state_next;

    logic signed [PointW-1:0] off_x_reg, off_y_reg;
    logic signed [RotW-1:0]   rot_reg;
    logic signed [PointW-1:0] px_reg, py_reg;
    logic signed [ShW-1:0]    sh_reg;
    logic        [ElW-1:0]    el_reg;
    logic                     flip_reg;
    logic signed [CxW-1:0]    c_reg, s_reg;
    logic [2:0]               op_reg;
    logic signed [ProdW-1:0]  prod_reg, acc_x_reg, acc_y_reg;
    logic signed [WorldW-1:0] wx_reg, wy_reg;
    logic [SumW-1:0]          sum_reg;
    logic [RootW-1:0]         ra_reg, rb_reg;
    logic signed [CzW-1:0]    zacos_reg;
    logic                     m_valid_reg;
    logic                     m_reach_reg;
    logic [63:0]              m_data_reg;

    logic signed [RotW:0]     a1, a2, a3;
    logic                     fl;
    logic signed [CxW-1:0]    mul_a;
    logic signed [WorldW-1:0] mul_b;
    logic signed [ProdW-1:0]  rnd_x, rnd_y;
    logic                     reach;
    logic [SumW-1:0]          rest;
    logic signed [CxW-1:0]    bx, by;
    logic signed [CzW-1:0]    zat, zac, sh_full, el_full;

    logic                     cs_start, cs_mode, cs_done;
    logic signed [CxW-1:0]    cs_x0, cs_y0, cs_x, cs_y;
    logic signed [CzW-1:0]    cs_z0, cs_z;
    logic                     sq_start, sq_done;
    logic [SqW-1:0]           sq_val;
    logic [RootW-1:0]         sq_root;

    fttl_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(cs_start), .vec_mode(cs_mode),
        .x_in(cs_x0), .y_in(cs_y0), .z_in(cs_z0), .done(cs_done),
        .x_out(cs_x), .y_out(cs_y), .z_out(cs_z)
    );

    fttl_isqrt u_isqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start), .value(sq_val),
        .done(sq_done), .root(sq_root)
    );

    // angle fold into [-90, 90] degrees
    always_comb begin
        a1 = {rot_reg[RotW-1], rot_reg};
        if (a1 >= 14'sd2880)       a1 = a1 - 14'sd2880;
        else if (a1 <= -14'sd2880) a1 = a1 + 14'sd2880;
        a2 = a1;
        if (a2 >= 14'sd1440)      a2 = a2 - 14'sd2880;
        else if (a2 < -14'sd1440) a2 = a2 + 14'sd2880;
        a3 = a2;
        fl = 1'b0;
        if (a3 > 14'sd720) begin
            a3 = a3 - 14'sd1440;
            fl = 1'b1;
        end else if (a3 < -14'sd720) begin
            a3 = a3 + 14'sd1440;
            fl = 1'b1;
        end
    end

    always_comb begin
        case (op_reg)
            3'd0:    begin mul_a = c_reg; mul_b = WorldW'(px_reg); end
            3'd1:    begin mul_a = s_reg; mul_b = WorldW'(py_reg); end
            3'd2:    begin mul_a = c_reg; mul_b = WorldW'(py_reg); end
            3'd3:    begin mul_a = s_reg; mul_b = WorldW'(px_reg); end
            3'd4:    begin mul_a = CxW'(wx_reg); mul_b = wx_reg; end
            default: begin mul_a = CxW'(wy_reg); mul_b = wy_reg; end
        endcase
    end

    always_comb begin
        rnd_x = (acc_x_reg + (ProdW'(1) <<< 29)) >>> 30;
        rnd_y = (acc_y_reg + (ProdW'(1) <<< 29)) >>> 30;
        reach = sum_reg < ReachQ16;
        rest  = ReachQ16 - sum_reg;
        bx = CxW'(wx_reg) <<< 12;
        by = CxW'(wy_reg) <<< 12;
        zac = cs_z;
        if (zac < 0)         zac = '0;
        if (zac > Deg90Q16)  zac = Deg90Q16;
        zat = cs_z;
        if (wx_reg == '0 && wy_reg == '0) zat = '0;
        if (zat > Deg180Q16)  zat = Deg180Q16;
        if (zat < -Deg180Q16) zat = -Deg180Q16;
        sh_full = (zacos_reg + zat + CzW'(4096)) >>> 13;
        el_full = (((Deg90Q16 - zacos_reg) <<< 1) + CzW'(4096)) >>> 13;
        if (sh_full < -CzW'(1440)) sh_full = -CzW'(1440);
        if (sh_full > CzW'(2160))  sh_full = CzW'(2160);
        if (el_full < 0)           el_full = '0;
        if (el_full > CzW'(1440))  el_full = CzW'(1440);
    end

    always_comb begin
        state_next = state_reg;
        cs_start = 1'b0;
        cs_mode  = 1'b0;
        cs_x0 = GainQ30;
        cs_y0 = '0;
        cs_z0 = CzW'(a3) <<< 13;
        sq_start = 1'b0;
        sq_val = {1'b0, sum_reg[24:0], 20'd0};
        unique case (state_reg)
            S_IDLE:    if (s_tvalid) state_next = S_ROT;
            S_ROT: begin
                cs_start = 1'b1;
                state_next = S_ROT_WAIT;
            end
            S_ROT_WAIT: if (cs_done) state_next = S_MUL;
            S_MUL:     state_next = S_ACC;
            S_ACC: begin
                if (op_reg == 3'd3)      state_next = S_WORLD;
                else if (op_reg == 3'd5) state_next = S_REACH;
                else                     state_next = S_MUL;
            end
            S_WORLD:   state_next = S_MUL;
            S_REACH:   state_next = reach ? S_SQRT_A : S_FINAL;
            S_SQRT_A: begin
                sq_start = 1'b1;
                state_next = S_SQRT_A_WAIT;
            end
            S_SQRT_A_WAIT: if (sq_done) state_next = S_SQRT_B;
            S_SQRT_B: begin
                sq_start = 1'b1;
                sq_val = {1'b0, rest[24:0], 20'd0};
                state_next = S_SQRT_B_WAIT;
            end
            S_SQRT_B_WAIT: if (sq_done) state_next = S_ACOS;
            S_ACOS: begin
                cs_start = 1'b1;
                cs_mode  = 1'b1;
                cs_x0 = CxW'(ra_reg);
                cs_y0 = CxW'(rb_reg);
                cs_z0 = '0;
                state_next = S_ACOS_WAIT;
            end
            S_ACOS_WAIT: if (cs_done) state_next = S_ATAN;
            S_ATAN: begin
                cs_start = 1'b1;
                cs_mode  = 1'b1;
                if (wx_reg < 0 && wy_reg >= 0) begin
                    cs_x0 = by;  cs_y0 = -bx; cs_z0 = Deg90Q16;
                end else if (wx_reg < 0) begin
                    cs_x0 = -by; cs_y0 = bx;  cs_z0 = -Deg90Q16;
                end else begin
                    cs_x0 = bx;  cs_y0 = by;  cs_z0 = '0;
                end
                state_next = S_ATAN_WAIT;
            end
            S_ATAN_WAIT: if (cs_done) state_next = S_FINAL;
            S_FINAL:   if (!m_valid_reg || m_tready) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            off_x_reg   <= '0;
            off_y_reg   <= '0;
            rot_reg     <= '0;
            sh_reg      <= ShW'(720);
            el_reg      <= ElW'(1440);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    RegOffX: off_x_reg <= cfg_wr_data;
                    RegOffY: off_y_reg <= cfg_wr_data;
                    RegRot:  rot_reg   <= cfg_wr_data[RotW-1:0];
                    default: ;
                endcase
            end
            if (state_reg == S_FINAL && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
                if (reach) begin
                    sh_reg <= sh_full[ShW-1:0];
                    el_reg <= el_full[ElW-1:0];
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (state_reg == S_IDLE && s_tvalid) begin
            px_reg <= s_tdata[17:0];
            py_reg <= s_tdata[35:18];
            op_reg <= '0;
        end
        if (state_reg == S_ROT) flip_reg <= fl;
        if (state_reg == S_ROT_WAIT && cs_done) begin
            c_reg <= flip_reg ? -cs_x : cs_x;
            s_reg <= flip_reg ? -cs_y : cs_y;
        end
        if (state_reg == S_MUL) prod_reg <= mul_a * mul_b;
        if (state_reg == S_ACC) begin
            op_reg <= op_reg + 1'b1;
            case (op_reg)
                3'd0:    acc_x_reg <= prod_reg;
                3'd1:    acc_x_reg <= acc_x_reg + prod_reg;
                3'd2:    acc_y_reg <= prod_reg;
                3'd3:    acc_y_reg <= acc_y_reg - prod_reg;
                3'd4:    sum_reg   <= prod_reg[SumW-1:0];
                default: sum_reg   <= sum_reg + prod_reg[SumW-1:0];
            endcase
        end
        if (state_reg == S_WORLD) begin
            wx_reg <= rnd_x[WorldW-1:0] + WorldW'(off_x_reg);
            wy_reg <= rnd_y[WorldW-1:0] + WorldW'(off_y_reg);
        end
        if (state_reg == S_SQRT_A_WAIT && sq_done) ra_reg <= sq_root;
        if (state_reg == S_SQRT_B_WAIT && sq_done) rb_reg <= sq_root;
        if (state_reg == S_ACOS_WAIT && cs_done) zacos_reg <= zac;
        if (state_reg == S_FINAL && (!m_valid_reg || m_tready)) begin
            m_reach_reg <= reach;
            if (reach) begin
                m_data_reg <= {el_full[ElW-1:0], sh_full[ShW-1:0], wy_reg, wx_reg};
            end else begin
                m_data_reg <= {el_reg, sh_reg, wy_reg, wx_reg};
            end
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_reach_reg;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import fttl_pkg::*;

    localparam logic [1:0] RegUnused = 2'd3;
    localparam int NumPhases = 8;
    localparam int PhaseItems = 166;
    localparam int QuietLimit = 20000;
    localparam int TailCycles = 300;
    localparam int Steps = 16;

    typedef struct packed {
        logic              reach;
        logic [WorldW-1:0] wx;
        logic [WorldW-1:0] wy;
        logic [ShW-1:0]    sh;
        logic [ElW-1:0]    el;
    } ik_word_t;

    typedef struct {
        int       px;
        int       py;
        bit       typed;
        ik_word_t want;
    } point_row_t;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [39:0]     s_tdata = '0;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [63:0]     m_tdata;
    logic            m_tuser;
    logic            cfg_wr_en = 1'b0;
    logic [1:0]      cfg_addr = RegOffX;
    logic [CfgW-1:0] cfg_wr_data = '0;

    frame_transform_two_link_ik #(.CORDIC_STEPS(Steps)) DUT (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predictor state: frame setup and held joint angles
    longint frame_ox = 0, frame_oy = 0, frame_rot = 0;
    longint held_sh = 720, held_el = 1440;

    ik_word_t   joint_q[$];
    point_row_t dir_rows[$];
    int  idle_pct = 0, stall_pct = 0;
    int  errors = 0, n_in = 0, n_out = 0, n_reach = 0, quiet = 0;

    function automatic longint atan_step(int i);
        return longint'(atan_lut(i[StepW-1:0]));
    endfunction

    function automatic longint vec_angle(longint x, longint y);
        longint z = 0;
        longint dx, dy;
        for (int i = 0; i < Steps; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y < 0) begin
                x -= dx; y += dy; z -= atan_step(i);
            end else begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        return z;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic ik_word_t solve_joints(longint px, longint py);
        ik_word_t res;
        longint a, x, y, z, dx, dy, c, s, wx, wy, sum, za, zt, sh, el;
        bit flip;
        a = frame_rot % 2880;
        flip = 0;
        if (a >= 1440) a -= 2880;
        if (a < -1440) a += 2880;
        if (a > 720) begin
            a -= 1440; flip = 1;
        end else if (a < -720) begin
            a += 1440; flip = 1;
        end
        z = a * 8192;
        x = 652032874;
        y = 0;
        for (int i = 0; i < Steps; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_step(i);
            end else begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
        wx = ((c * px + s * py + (64'sd1 <<< 29)) >>> 30) + frame_ox;
        wy = ((-s * px + c * py + (64'sd1 <<< 29)) >>> 30) + frame_oy;
        sum = wx * wx + wy * wy;
        res.reach = sum < 26214400;
        if (res.reach) begin
            za = vec_angle(longint'(int_sqrt(sum << 20)),
                           longint'(int_sqrt((26214400 - sum) << 20)));
            x = wx * 4096;
            y = wy * 4096;
            if (x == 0 && y == 0) zt = 0;
            else if (x < 0 && y >= 0) zt = 90 * 65536 + vec_angle(y, -x);
            else if (x < 0) zt = -90 * 65536 + vec_angle(-y, x);
            else zt = vec_angle(x, y);
            if (zt > 180 * 65536) zt = 180 * 65536;
            if (zt < -180 * 65536) zt = -180 * 65536;
            if (za < 0) za = 0;
            if (za > 90 * 65536) za = 90 * 65536;
            sh = (za + zt + 4096) >>> 13;
            el = (2 * (90 * 65536 - za) + 4096) >>> 13;
            if (sh < -1440) sh = -1440;
            if (sh > 2160) sh = 2160;
            if (el < 0) el = 0;
            if (el > 1440) el = 1440;
            held_sh = sh;
            held_el = el;
        end
        res.wx = wx[WorldW-1:0];
        res.wy = wy[WorldW-1:0];
        res.sh = held_sh[ShW-1:0];
        res.el = held_el[ElW-1:0];
        return res;
    endfunction

    // accept, predict and check on the same edge the DUT sees
    always @(posedge aclk) begin
        ik_word_t got, want, calc;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tdata[19:0], m_tdata[39:20], m_tdata[52:40], m_tdata[63:53]};
                n_out++;
                if (got.reach) n_reach++;
                if (joint_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word %h", $time, got);
                end else begin
                    want = joint_q.pop_front();
                    if (got.reach !== want.reach)
                        $display("%0t: reachable exp %0d got %0d", $time, want.reach, got.reach);
                    if (got.wx !== want.wx)
                        $display("%0t: world_x exp %h got %h", $time, want.wx, got.wx);
                    if (got.wy !== want.wy)
                        $display("%0t: world_y exp %h got %h", $time, want.wy, got.wy);
                    if (got.sh !== want.sh)
                        $display("%0t: shoulder exp %0d got %0d", $time,
                                 $signed(want.sh), $signed(got.sh));
                    if (got.el !== want.el)
                        $display("%0t: elbow exp %0d got %0d", $time, want.el, got.el);
                    if (got !== want) errors++;
                end
            end
            if (s_tvalid && s_tready) begin
                calc = solve_joints(longint'($signed(s_tdata[17:0])),
                                    longint'($signed(s_tdata[35:18])));
                if (n_in < dir_rows.size() && dir_rows[n_in].typed)
                    joint_q = {joint_q, dir_rows[n_in].want};
                else
                    joint_q = {joint_q, calc};
                n_in++;
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    RegOffX: frame_ox = longint'($signed(cfg_wr_data));
                    RegOffY: frame_oy = longint'($signed(cfg_wr_data));
                    RegRot:  frame_rot = longint'($signed(cfg_wr_data[RotW-1:0]));
                    default: ;
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet == QuietLimit) begin
            $display("[frame_transform_two_link_ik] ERROR");
            $finish;
        end
    end

    task automatic send_point(int px, int py);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, py[PointW-1:0], px[PointW-1:0]};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (joint_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, int value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value[CfgW-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic int rand_coord();
        int k;
        k = $urandom_range(99);
        if (k < 70) return $urandom_range(7000) - 3500;
        if (k < 85) return $urandom_range(12000) - 6000;
        return int'($signed(18'($urandom)));
    endfunction

    task automatic add_row(int px, int py);
        point_row_t r;
        r.px = px;
        r.py = py;
        r.typed = 0;
        r.want = '0;
        dir_rows = {dir_rows, r};
    endtask

    initial begin
        point_row_t r;
        int ox, oy, rot;
        // origin after reset: straight up, folded elbow
        r.px = 0; r.py = 0; r.typed = 1;
        r.want = '{reach: 1'b1, wx: '0, wy: '0, sh: 13'd720, el: 11'd0};
        dir_rows = {dir_rows, r};
        add_row(131071, 131071);
        add_row(-131072, -131072);
        add_row(-131072, 131071);
        add_row(131071, -131072);
        add_row(2560, 0);
        add_row(0, 2560);
        add_row(-2560, 0);
        add_row(0, -2560);
        add_row(-2560, -1);
        add_row(-2560, 1);
        add_row(5119, 0);
        add_row(5120, 0);
        add_row(0, -5119);
        add_row(3620, 3620);
        add_row(1, 0);
        add_row(-1, 0);
        add_row(0, 1);
        add_row(-3000, -3000);
        add_row(9000, 9000);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) send_point(dir_rows[i].px, dir_rows[i].py);
        drain();

        for (int ph = 0; ph < NumPhases; ph++) begin
            case (ph)
                0: begin ox = 0; oy = 0; rot = 0; end
                1: begin ox = 131071; oy = -131072; rot = 2880; end
                2: begin ox = -131072; oy = 131071; rot = -2880; end
                3: begin ox = 0; oy = 0; rot = 1440; end
                4: begin ox = 500; oy = -700; rot = 720; end
                default: begin
                    ox = $urandom_range(4000) - 2000;
                    oy = $urandom_range(4000) - 2000;
                    rot = $urandom_range(5760) - 2880;
                end
            endcase
            write_reg(RegOffX, ox);
            write_reg(RegOffY, oy);
            write_reg(RegRot, rot);
            if (ph == 4) write_reg(RegUnused, $urandom);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 87; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 87; end
                default: begin idle_pct = 18; stall_pct = 18; end
            endcase
            for (int n = 0; n < PhaseItems; n++) begin
                send_point(rand_coord(), rand_coord());
                // hold off the sender until the pipe is empty
                if (n == PhaseItems / 2) drain();
            end
            drain();
        end

        stall_pct = 0;
        repeat (TailCycles) @(posedge aclk);
        $display("covered %0d points, %0d words out, %0d reachable, %0d frame setups",
                 n_in, n_out, n_reach, NumPhases + 1);
        if (errors == 0 && joint_q.size() == 0) begin
            $display("[frame_transform_two_link_ik] OK");
        end else begin
            $display("[frame_transform_two_link_ik] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/fttl_pkg.sv
rtl/core/fttl_cordic.sv
rtl/core/fttl_isqrt.sv
rtl/core/frame_transform_two_link_ik.sv
dv/tb.sv
